/* src/assert_macros.svh */
// assert_macros.svh: assertion helpers shared by the lvg RTL files.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define LVG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define LVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lvg_pkg.sv */
// lvg_pkg: types, widths and constants of the local variance gate filter.
// No dependencies; used by lvg_fifo, lvg_front, lvg_back and the top module.
`default_nettype none

package lvg_pkg;

  // Geometry and sizes
  localparam int DEFAULT_MAX_WIDTH = 256;
  localparam int WINDOW            = 3;
  localparam int QUEUE_DEPTH       = 4;
  localparam int MIN_DIM           = 3;
  localparam int MAX_HEIGHT        = 256;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int POS_W      = 8;
  localparam int ROW_W      = 9;
  localparam int LIMIT_W    = 21;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 21;

  // Arithmetic widths: column sum, column sum of squares, window sums, 81*variance
  localparam int CSUM_W = 10;
  localparam int CSQ_W  = 16;
  localparam int S1_W   = 12;
  localparam int S2_W   = 18;
  localparam int V_W    = S2_W + 3;

  // Register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VAR_LIMIT    = 2'd2;

  // Reset values of the registers
  localparam int RESET_FRAME_WIDTH  = 160;
  localparam int RESET_FRAME_HEIGHT = 160;
  localparam int RESET_VAR_LIMIT    = 324;

  typedef struct packed {
    logic                    action;
    logic signed [PIX_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic                    frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic signed [PIX_W-1:0] pix;        // pixel, already zeroed for padding
    logic [POS_W-1:0]        orow;
    logic [POS_W-1:0]        ocol;
    logic                    emit;       // a result leaves for this item
    logic                    frame_end;
    logic                    same_col;   // previous item used the same column
    logic                    top_zero;   // top row of this column lies above the frame
    logic                    mask_left;  // left window column lies outside the frame
    logic                    mask_right; // right window column lies outside the frame
  } cmd_t;

endpackage

`default_nettype wire

/* src/lvg_stream_if.sv */
// lvg_stream_if: valid/ready channel with a typed payload.
// Used for the pixel, result and configuration channels; no dependencies.
`default_nettype none

interface lvg_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/lvg_ram.sv */
// lvg_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module lvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/lvg_fifo.sv */
// lvg_fifo: short register queue between the front end and the back end.
// Depends on lvg_pkg for the default depth and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lvg_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = lvg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LVG_ASSERT(a_no_push_full, clk, rst, push |-> (!full || pop), "push into a full queue")
  `LVG_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

/* src/lvg_front.sv */
// lvg_front: configuration registers, input position counters and item classification.
// Depends on lvg_pkg, lvg_stream_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lvg_front #(
  parameter int MAX_WIDTH = lvg_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  lvg_stream_if.sink                    pixels,
  lvg_stream_if.sink                    cfg,
  input  logic                          q_full,
  output logic                          q_push,
  output lvg_pkg::cmd_t                 q_cmd,
  output logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic [lvg_pkg::LIMIT_W-1:0]   limit
);

  import lvg_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (WW > ROW_W) ? WW : ROW_W;
  localparam int OW     = (WW > POS_W) ? WW : POS_W;
  localparam int RX     = ROW_W + 1;
  localparam int W_INIT = (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;

  logic [WW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [CW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic [CW-1:0]    prev_col;

  // Configuration: width and height are stored already clamped.
  logic [EW-1:0]    w_raw;
  logic [WW-1:0]    w_clamped;
  logic [ROW_W-1:0] h_raw;
  logic [ROW_W-1:0] h_clamped;

  assign cfg.ready = 1'b1;
  assign w_raw     = EW'(cfg.data.wdata[ROW_W-1:0]);
  assign h_raw     = cfg.data.wdata[ROW_W-1:0];

  always_comb begin
    if (w_raw < EW'(MIN_DIM)) begin
      w_clamped = WW'(MIN_DIM);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(w_raw);
    end
    if (h_raw < ROW_W'(MIN_DIM)) begin
      h_clamped = ROW_W'(MIN_DIM);
    end else if (h_raw > ROW_W'(MAX_HEIGHT)) begin
      h_clamped = ROW_W'(MAX_HEIGHT);
    end else begin
      h_clamped = h_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_eff <= WW'(W_INIT);
      h_eff <= ROW_W'(RESET_FRAME_HEIGHT);
      limit <= LIMIT_W'(RESET_VAR_LIMIT);
    end else if (cfg.valid) begin
      unique case (cfg.data.addr)
        REG_FRAME_WIDTH:  w_eff <= w_clamped;
        REG_FRAME_HEIGHT: h_eff <= h_clamped;
        REG_VAR_LIMIT:    limit <= cfg.data.wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the item being taken.
  logic             col_wrap;
  logic [ROW_W-1:0] r_step;
  logic [ROW_W-1:0] r_cur;
  logic [CW-1:0]    c_cur;
  logic [RX-1:0]    r_x;
  logic [RX-1:0]    h_plus1;
  logic             c_zero;
  logic             c_one;
  logic [WW-1:0]    c_inc;
  logic             row_end;
  logic [OW-1:0]    ocol_wide;
  logic [ROW_W-1:0] orow_wide;
  logic             accept;

  assign col_wrap = (WW'(col) >= w_eff);
  assign r_step   = col_wrap ? row + 1'b1 : row;
  assign h_plus1  = {1'b0, h_eff} + 1'b1;
  assign r_cur    = ({1'b0, r_step} > h_plus1) ? '0 : r_step;
  assign c_cur    = col_wrap ? '0 : col;
  assign r_x      = {1'b0, r_cur};
  assign c_zero   = (c_cur == '0);
  assign c_one    = (c_cur == CW'(1));
  assign c_inc    = WW'(c_cur) + 1'b1;
  assign row_end  = (c_inc >= w_eff);

  // The result lags by one row plus one pixel; column zero reports the previous row's end.
  assign orow_wide = c_zero ? r_cur - ROW_W'(2) : r_cur - ROW_W'(1);
  assign ocol_wide = c_zero ? OW'(w_eff) - 1'b1 : OW'(c_cur) - 1'b1;

  always_comb begin
    q_cmd.pix        = (pixels.data.action || (r_cur >= h_eff)) ? '0 : pixels.data.pixel_in;
    q_cmd.orow       = orow_wide[POS_W-1:0];
    q_cmd.ocol       = ocol_wide[POS_W-1:0];
    q_cmd.emit       = c_zero ? ((r_x >= RX'(2)) && (r_x <= h_plus1))
                              : ((r_x >= RX'(1)) && (r_x <= {1'b0, h_eff}));
    q_cmd.frame_end  = c_zero && (r_x == h_plus1);
    q_cmd.same_col   = (c_cur == prev_col);
    q_cmd.top_zero   = (r_cur < ROW_W'(2));
    q_cmd.mask_left  = c_one;
    q_cmd.mask_right = c_zero;
  end

  assign q_col        = c_cur;
  assign pixels.ready = !q_full;
  assign accept       = pixels.valid && !q_full;
  assign q_push       = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      prev_col <= '0;
    end else if (accept) begin
      prev_col <= c_cur;
      if (q_cmd.frame_end) begin
        col <= '0;
        row <= '0;
      end else if (row_end) begin
        col <= '0;
        row <= r_cur + 1'b1;
      end else begin
        col <= CW'(c_inc);
        row <= r_cur;
      end
    end
  end

  `LVG_ASSERT_NEXT(a_frame_restart, clk, rst, accept && q_cmd.frame_end, (row == '0) && (col == '0), "counters did not restart after frame end")

endmodule

`default_nettype wire

/* src/lvg_back.sv */
// lvg_back: line stores, column window and variance pipeline feeding the result register.
// Depends on lvg_pkg, lvg_stream_if, lvg_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lvg_back #(
  parameter int MAX_WIDTH = lvg_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  lvg_pkg::cmd_t                q_cmd,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
  output logic                         q_pop,
  input  logic [lvg_pkg::LIMIT_W-1:0]  limit,
  lvg_stream_if.source                 results
);

  import lvg_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic adv;
  logic out_valid;
  out_item_t out_item;

  // The whole pipeline moves together whenever the result register can take a new value.
  assign adv           = !out_valid || results.ready;
  assign q_pop         = adv && q_valid;
  assign results.valid = out_valid;
  assign results.data  = out_item;

  // Stage 1: line store read data arrives; build the new window column.
  logic          s1_valid;
  cmd_t          s1_cmd;
  logic [CW-1:0] s1_col;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_cmd <= q_cmd;
      s1_col <= q_col;
    end
  end

  logic [PIX_W-1:0] upper_q;
  logic [PIX_W-1:0] middle_q;
  logic             store_we;
  logic signed [PIX_W-1:0] last_mid;
  logic signed [PIX_W-1:0] last_pix;
  logic signed [PIX_W-1:0] top_raw;
  logic signed [PIX_W-1:0] mid_raw;
  logic signed [PIX_W-1:0] pix_v;
  logic signed [PIX_W-1:0] top_v;

  assign store_we = adv && s1_valid;

  lvg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_col),
    .wdata (mid_raw),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (upper_q)
  );

  lvg_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (s1_col),
    .wdata (pix_v),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (middle_q)
  );

  // Back-to-back items on the same column (a new frame starting at column zero)
  // read the store in the cycle it is written, so the fresh values are forwarded.
  assign top_raw = s1_cmd.same_col ? last_mid : $signed(upper_q);
  assign mid_raw = s1_cmd.same_col ? last_pix : $signed(middle_q);
  assign pix_v   = s1_cmd.pix;
  assign top_v   = s1_cmd.top_zero ? '0 : top_raw;

  always_ff @(posedge clk) begin
    if (store_we) begin
      last_mid <= mid_raw;
      last_pix <= pix_v;
    end
  end

  logic signed [2*PIX_W-1:0] sq_top;
  logic signed [2*PIX_W-1:0] sq_mid;
  logic signed [2*PIX_W-1:0] sq_pix;
  logic signed [CSUM_W-1:0]  csum;
  logic [CSQ_W-1:0]          csq;

  assign sq_top = top_v * top_v;
  assign sq_mid = mid_raw * mid_raw;
  assign sq_pix = pix_v * pix_v;
  assign csum   = CSUM_W'(top_v) + CSUM_W'(mid_raw) + CSUM_W'(pix_v);
  assign csq    = CSQ_W'(unsigned'(sq_top)) + CSQ_W'(unsigned'(sq_mid))
                + CSQ_W'(unsigned'(sq_pix));

  // Window of per-column sums; column WINDOW-1 is the newest.
  logic signed [CSUM_W-1:0] col_sum [WINDOW];
  logic [CSQ_W-1:0]         col_sq  [WINDOW];
  logic signed [PIX_W-1:0]  mid_newest;
  logic signed [PIX_W-1:0]  mid_center;

  always_ff @(posedge clk) begin
    if (store_we) begin
      for (int j = 0; j < WINDOW - 1; j++) begin
        col_sum[j] <= col_sum[j+1];
        col_sq[j]  <= col_sq[j+1];
      end
      col_sum[WINDOW-1] <= csum;
      col_sq[WINDOW-1]  <= csq;
      mid_center        <= mid_newest;
      mid_newest        <= mid_raw;
    end
  end

  // Stage 2: window sums with the edge columns masked.
  logic s2_valid;
  cmd_t s2_cmd;
  logic signed [S1_W-1:0] sum1;
  logic [S2_W-1:0]        sum2;

  always_ff @(posedge clk) begin
    if (store_we) begin
      s2_cmd <= s1_cmd;
    end
  end

  always_comb begin
    sum1 = S1_W'(col_sum[1]);
    sum2 = S2_W'(col_sq[1]);
    if (!s2_cmd.mask_left) begin
      sum1 = sum1 + S1_W'(col_sum[0]);
      sum2 = sum2 + S2_W'(col_sq[0]);
    end
    if (!s2_cmd.mask_right) begin
      sum1 = sum1 + S1_W'(col_sum[WINDOW-1]);
      sum2 = sum2 + S2_W'(col_sq[WINDOW-1]);
    end
  end

  // Stage 3: registered sums of the items that give a result.
  logic                    s3_valid;
  cmd_t                    s3_cmd;
  logic signed [S1_W-1:0]  s3_sum1;
  logic [S2_W-1:0]         s3_sum2;
  logic signed [PIX_W-1:0] s3_center;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd    <= s2_cmd;
      s3_sum1   <= sum1;
      s3_sum2   <= sum2;
      s3_center <= mid_center;
    end
  end

  // Stage 4: square of the sum and nine times the sum of squares.
  logic                      s4_valid;
  cmd_t                      s4_cmd;
  logic signed [2*S1_W-1:0]  sum1_sq;
  logic [V_W-1:0]            s4_sq;
  logic [V_W-1:0]            s4_nine;
  logic signed [PIX_W-1:0]   s4_center;

  assign sum1_sq = s3_sum1 * s3_sum1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_cmd    <= s3_cmd;
      s4_sq     <= sum1_sq[V_W-1:0];
      s4_nine   <= {s3_sum2, 3'b000} + V_W'(s3_sum2);
      s4_center <= s3_center;
    end
  end

  // Result: 81 times the variance against the threshold.
  logic signed [V_W:0] var81;
  logic                keep;

  assign var81 = $signed({1'b0, s4_nine}) - $signed({1'b0, s4_sq});
  assign keep  = !var81[V_W] && (var81[V_W-1:0] > limit);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.pixel_out <= keep ? s4_center : '0;
      out_item.out_row   <= s4_cmd.orow;
      out_item.out_col   <= s4_cmd.ocol;
      out_item.frame_end <= s4_cmd.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid && s2_cmd.emit;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  `LVG_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !adv, s1_valid && $stable(s1_col), "stage 1 item moved during a stall")
  `LVG_ASSERT(a_end_emits, clk, rst, (s2_valid && s2_cmd.frame_end) |-> s2_cmd.emit, "frame end on an item without a result")

endmodule

`default_nettype wire

/* src/local_variance_gate_filter.sv */
// Local variance gate filter: 3x3 local variance test on a signed 8-bit pixel stream.
// Channels: pixels (sink, lvg_pkg::in_item_t), results (source, lvg_pkg::out_item_t) and
// cfg (sink, lvg_pkg::cfg_item_t, register index in addr, value in wdata).
// Pixels arrive in raster order; after each frame the sender issues frame_width+1 flush
// items so that the last row's results come out. Each result belongs to the pixel one row
// plus one pixel earlier. One item is taken per cycle; the pipeline runs at one item per clock
// as long as results are taken. The line stores are one simple dual-port RAM each, read and
// written once per item.
// Reset sets width and height to 160, the threshold to 324, starts a new frame and
// empties the pipeline; there is no store clearing pass, entries are masked until written.
// When results.ready is low the pending result is held, the pipeline freezes and a
// four-entry queue absorbs incoming items before pixels.ready drops.
// Configuration writes are always taken and belong between frames, with the block idle.
// Depends on lvg_pkg, lvg_stream_if, lvg_front, lvg_fifo and lvg_back.
`default_nettype none

module local_variance_gate_filter #(
  parameter int MAX_WIDTH = lvg_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  lvg_stream_if.sink   pixels,
  lvg_stream_if.source results,
  lvg_stream_if.sink   cfg
);

  import lvg_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = $bits(cmd_t) + CW;

  logic               push;
  logic               pop;
  logic               full;
  logic               empty;
  cmd_t               f_cmd;
  logic [CW-1:0]      f_col;
  cmd_t               b_cmd;
  logic [CW-1:0]      b_col;
  logic [QW-1:0]      q_din;
  logic [QW-1:0]      q_dout;
  logic [LIMIT_W-1:0] limit;

  lvg_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk    (clk),
    .rst    (rst),
    .pixels (pixels),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_cmd  (f_cmd),
    .q_col  (f_col),
    .limit  (limit)
  );

  assign q_din = {f_col, f_cmd};

  lvg_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .full  (full),
    .empty (empty)
  );

  assign b_col = q_dout[QW-1 -: CW];
  assign b_cmd = cmd_t'(q_dout[$bits(cmd_t)-1:0]);

  lvg_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!empty),
    .q_cmd   (b_cmd),
    .q_col   (b_col),
    .q_pop   (pop),
    .limit   (limit),
    .results (results)
  );

endmodule

`default_nettype wire

/* tb/local_variance_gate_filter_checker.sv */
`timescale 1ns / 100ps
// Result checker for local_variance_gate_filter: follows the pixel, result and register
// channels, predicts every gated pixel and compares it with what the block delivers.
// Depends on lvg_pkg.

module local_variance_gate_filter_checker
  import lvg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pix_valid,
  input  logic      pix_ready,
  input  in_item_t  pix_item,
  input  logic      res_valid,
  input  logic      res_ready,
  input  out_item_t res_item,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_write,
  output int        results_due,
  output int        mismatch_count
);

  // Own copy of the register file and of the filter state.
  int cfg_width, cfg_height, cfg_limit;
  int row_pos, col_pos;
  logic signed [PIX_W-1:0] upper_row [DEFAULT_MAX_WIDTH];
  logic signed [PIX_W-1:0] middle_row [DEFAULT_MAX_WIDTH];
  logic signed [PIX_W-1:0] win [WINDOW][WINDOW];

  out_item_t gated_pixels_due [$];

  initial begin
    mismatch_count = 0;
    results_due = 0;
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Slides the window by one item and returns 1 when a gated pixel leaves for it.
  function automatic bit gate_next_pixel(input in_item_t item, output out_item_t res);
    int w, h, r, c, orow, ocol, rp, cp, s1, s2, p, v, i, j;
    logic signed [PIX_W-1:0] pix, top, mid;
    w = (cfg_width < MIN_DIM) ? MIN_DIM :
        (cfg_width > DEFAULT_MAX_WIDTH) ? DEFAULT_MAX_WIDTH : cfg_width;
    h = (cfg_height < MIN_DIM) ? MIN_DIM : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
    res = '0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos > h + 1) row_pos = 0;
    r = row_pos;
    c = col_pos;

    // Flush ticks and anything below the last row enter as zero.
    pix = (item.action || r >= h) ? '0 : item.pixel_in;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = pix;
    for (i = 0; i < WINDOW; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = pix;

    if (c >= 1) begin
      orow = r - 1;
      ocol = c - 1;
    end else begin
      orow = r - 2;
      ocol = w - 1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
    end
    if (orow < 0 || orow >= h || ocol >= w) return 1'b0;

    s1 = 0;
    s2 = 0;
    for (i = 0; i < WINDOW; i++) begin
      rp = orow - 1 + i;
      if (rp >= 0 && rp < h) begin
        for (j = 0; j < WINDOW; j++) begin
          cp = ocol - 1 + j;
          if (cp >= 0 && cp < w) begin
            p = win[i][j];
            s1 += p;
            s2 += p * p;
          end
        end
      end
    end
    v = 9 * s2 - s1 * s1;

    res.pixel_out = (v > cfg_limit) ? win[1][1] : '0;
    res.out_row = orow[POS_W-1:0];
    res.out_col = ocol[POS_W-1:0];
    res.frame_end = (orow == h - 1 && ocol == w - 1);
    if (res.frame_end) begin
      row_pos = 0;
      col_pos = 0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want, next_res;
    if (rst) begin
      cfg_width = RESET_FRAME_WIDTH;
      cfg_height = RESET_FRAME_HEIGHT;
      cfg_limit = RESET_VAR_LIMIT;
      row_pos = 0;
      col_pos = 0;
      for (int k = 0; k < DEFAULT_MAX_WIDTH; k++) begin
        upper_row[k] = '0;
        middle_row[k] = '0;
      end
      for (int k = 0; k < WINDOW * WINDOW; k++) win[k / WINDOW][k % WINDOW] = '0;
      gated_pixels_due.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (gated_pixels_due.size() == 0) begin
          log_mismatch($sformatf("result with nothing due: pixel_out %0d row %0d col %0d end %0b",
                                 $signed(res_item.pixel_out), res_item.out_row,
                                 res_item.out_col, res_item.frame_end));
        end else begin
          want = gated_pixels_due.pop_front();
          if (res_item.pixel_out !== want.pixel_out)
            log_mismatch($sformatf("pixel_out at row %0d col %0d: expected %0d, got %0d",
                                   want.out_row, want.out_col, $signed(want.pixel_out),
                                   $signed(res_item.pixel_out)));
          if (res_item.out_row !== want.out_row)
            log_mismatch($sformatf("out_row: expected %0d, got %0d",
                                   want.out_row, res_item.out_row));
          if (res_item.out_col !== want.out_col)
            log_mismatch($sformatf("out_col at row %0d: expected %0d, got %0d",
                                   want.out_row, want.out_col, res_item.out_col));
          if (res_item.frame_end !== want.frame_end)
            log_mismatch($sformatf("frame_end at row %0d col %0d: expected %0b, got %0b",
                                   want.out_row, want.out_col, want.frame_end,
                                   res_item.frame_end));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_write.addr)
          REG_FRAME_WIDTH:  cfg_width = cfg_write.wdata[ROW_W-1:0];
          REG_FRAME_HEIGHT: cfg_height = cfg_write.wdata[ROW_W-1:0];
          REG_VAR_LIMIT:    cfg_limit = cfg_write.wdata;
          default: ;
        endcase
      end
      if (pix_valid && pix_ready) begin
        if (gate_next_pixel(pix_item, next_res)) gated_pixels_due.push_back(next_res);
      end
    end
    results_due = gated_pixels_due.size();
  end

endmodule

/* tb/local_variance_gate_filter_tb.sv */
`timescale 1ns / 100ps
// Testbench top for local_variance_gate_filter: clock, reset, frame and register stimulus,
// back-pressure on the result channel and the final verdict.
// Depends on lvg_pkg, lvg_stream_if, the filter RTL and local_variance_gate_filter_checker.

module local_variance_gate_filter_tb;
  import lvg_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;  // decodes to no register
  localparam logic [CFG_DATA_W-1:0] LIMIT_MAX = '1;
  localparam int SETTLE_CYCLES   = 32;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PHASE_ITEMS     = 400;

  logic clk = 1'b0;
  logic rst;
  logic drain_ready;
  int   results_due, mismatch_count;
  int   src_idle_pct, snk_idle_pct, items_sent, hold_off_requests;

  lvg_stream_if #(.T(in_item_t))  pixels_ch ();
  lvg_stream_if #(.T(out_item_t)) results_ch ();
  lvg_stream_if #(.T(cfg_item_t)) cfg_ch ();

  local_variance_gate_filter DUT (
    .clk(clk),
    .rst(rst),
    .pixels(pixels_ch),
    .results(results_ch),
    .cfg(cfg_ch)
  );

  local_variance_gate_filter_checker gate_check (
    .clk(clk),
    .rst(rst),
    .pix_valid(pixels_ch.valid),
    .pix_ready(pixels_ch.ready),
    .pix_item(pixels_ch.data),
    .res_valid(results_ch.valid),
    .res_ready(results_ch.ready),
    .res_item(results_ch.data),
    .cfg_valid(cfg_ch.valid),
    .cfg_ready(cfg_ch.ready),
    .cfg_write(cfg_ch.data),
    .results_due(results_due),
    .mismatch_count(mismatch_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("local_variance_gate_filter_tb: done, errors");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off whenever the stimulus asks for it.
  initial begin : result_sink
    int hold_left, requests_seen;
    hold_left = 0;
    requests_seen = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (requests_seen != hold_off_requests) begin
        requests_seen = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= drain_ready || ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_pixel(input logic act, input logic signed [PIX_W-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      pixels_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixels_ch.valid <= 1'b1;
    pixels_ch.data  <= in_item_t'{action: act, pixel_in: value};
    do @(posedge clk); while (!pixels_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cfg_item_t'{addr: idx, wdata: value};
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pixels_ch.valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
  endtask

  // Items that cause no result may still be in flight; give them time with ready held high.
  task automatic settle();
    wait_drained();
    drain_ready <= 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
    drain_ready <= 1'b0;
  endtask

  task automatic send_frame(input int w, input int h, input int style, input bit regeom);
    int n, pause_at, tail, base;
    logic [PIX_W-1:0] lo, hi;
    logic signed [PIX_W-1:0] value;
    base = $urandom_range(200) - 100;
    lo = $urandom_range(255);
    hi = $urandom_range(255);
    pause_at = ($urandom_range(3) == 0) ? $urandom_range(w * h - 1) : -1;
    for (n = 0; n < w * h; n++) begin
      case (style)
        0: value = $urandom_range(255);
        1: value = base + $urandom_range(6) - 3;
        2: value = (((n % w) / 3 + (n / w) / 2) % 2) ? lo : hi;
        default: begin
          case ($urandom_range(3))
            0: value = 127;
            1: value = -128;
            2: value = -1;
            default: value = 0;
          endcase
        end
      endcase
      if (n == pause_at) begin
        if (regeom) begin
          // Geometry change in the middle of a frame.
          settle();
          write_reg(REG_FRAME_WIDTH, $urandom_range(16, 3));
          write_reg(REG_FRAME_HEIGHT, $urandom_range(10, 3));
        end else begin
          wait_drained();
        end
      end
      push_pixel($urandom_range(99) < 3, value);
    end
    // Padding: mostly flush ticks, some pixel items past the frame, now and then a wrong count.
    tail = w + 1;
    if ($urandom_range(99) < 8) tail = $urandom_range(2 * w + 2);
    repeat (tail) push_pixel($urandom_range(99) < 80, $urandom_range(255));
  endtask

  initial begin : stimulus
    int k, phase, phase_start, w, h;
    logic [CFG_DATA_W-1:0] wval, hval, limit;
    logic signed [PIX_W-1:0] corner_frames [18];
    corner_frames = '{127, -128, 127, -128, 127, 127, -128, 127, -1,
                      0, 127, -128, 1, -1, 64, -64, 127, -128};
    pixels_ch.valid = 1'b0;
    pixels_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    drain_ready = 1'b0;
    hold_off_requests = 0;
    items_sent = 0;
    src_idle_pct = 23;
    snk_idle_pct = 76;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Smallest frame, every variance passes; the centre item is a flush tick.
    write_reg(REG_SPARE, LIMIT_MAX);
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_VAR_LIMIT, 0);
    for (k = 0; k < 9; k++) push_pixel(k == 4, corner_frames[k]);
    push_pixel(1'b1, 0);
    push_pixel(1'b0, 127);
    push_pixel(1'b1, -128);
    push_pixel(1'b1, 0);
    settle();

    // Width and height below the minimum with high bits set, threshold at its top.
    write_reg(REG_FRAME_WIDTH, 21'h1FFE01);
    write_reg(REG_FRAME_HEIGHT, 21'h100000);
    write_reg(REG_VAR_LIMIT, LIMIT_MAX);
    for (k = 9; k < 18; k++) push_pixel(1'b0, corner_frames[k]);
    repeat (4) push_pixel(1'b1, 0);
    settle();

    // Widest frame (width above the maximum) also fills every column of both line stores.
    write_reg(REG_FRAME_WIDTH, 511);
    write_reg(REG_FRAME_HEIGHT, 3);
    write_reg(REG_VAR_LIMIT, $urandom_range(200000));
    send_frame(256, 3, 0, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 23;
          snk_idle_pct = 76;
        end
        1: begin
          src_idle_pct = 76;
          snk_idle_pct = 23;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        settle();
        w = $urandom_range(16, 3);
        h = $urandom_range(10, 3);
        if (phase == 2 && items_sent == phase_start) begin
          w = 16;
          h = 8;
        end
        wval = w;
        hval = h;
        if ($urandom_range(3) == 0) wval[CFG_DATA_W-1:ROW_W] = $urandom;
        if ($urandom_range(3) == 0) hval[CFG_DATA_W-1:ROW_W] = $urandom;
        if (w == 3 && $urandom_range(1)) wval[ROW_W-1:0] = $urandom_range(2);
        if (h == 3 && $urandom_range(1)) hval[ROW_W-1:0] = $urandom_range(2);
        case ($urandom_range(4))
          0: limit = 0;
          1: limit = $urandom_range(500);
          2: limit = $urandom_range(50000);
          3: limit = $urandom_range(1400000);
          default: limit = LIMIT_MAX;
        endcase
        write_reg(REG_FRAME_WIDTH, wval);
        write_reg(REG_FRAME_HEIGHT, hval);
        write_reg(REG_VAR_LIMIT, limit);
        // With no idling, stop taking results for a while so the block backs up its input.
        if (phase == 2 && items_sent == phase_start) hold_off_requests <= hold_off_requests + 1;
        send_frame(w, h, $urandom_range(3), $urandom_range(2) == 0);
      end
    end

    // Tallest frame, height above the maximum.
    settle();
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 300);
    write_reg(REG_VAR_LIMIT, $urandom_range(2000));
    send_frame(3, 256, 1, 1'b0);

    settle();
    if (mismatch_count == 0 && results_due == 0) begin
      $display("local_variance_gate_filter_tb: done, clean");
    end else begin
      $display("local_variance_gate_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
